/* rtl/core/fsba_pkg.sv */
// Shared constants, codes and structs for the fit-strategy heap allocator.
`default_nettype none

package fsba_pkg;

  // Parameter defaults
  localparam int FREE_DEPTH_DEF  = 16;
  localparam int TAKEN_DEPTH_DEF = 16;
  localparam int SIZE_BITS_DEF   = 20;

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int REQ_SIZE_W = 20;
  localparam int STATUS_W   = 3;
  localparam int ENTRIES_W  = 5;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;

  // Placement modes; the unused code behaves as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAKEN_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b1;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [MODE_W-1:0] fit_mode;
    logic              bp_load;
    logic [ADDR_W-1:0] bp_value;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [ADDR_W-1:0]    result_addr;
    logic [STATUS_W-1:0]  status;
    logic                 from_break;
    logic [ADDR_W-1:0]    free_bytes;
    logic [ENTRIES_W-1:0] free_entries;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/fsba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fsba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/fsba_seq.sv */
// Request sequencer: table scans, compaction, placement and running totals.
`default_nettype none

module fsba_seq
  import fsba_pkg::*;
#(
  parameter int FREE_DEPTH  = FREE_DEPTH_DEF,
  parameter int TAKEN_DEPTH = TAKEN_DEPTH_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cfg_t                              cfg,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic                              req_type,
  input  wire logic [REQ_SIZE_W-1:0]             request_size,
  input  wire logic [ADDR_W-1:0]                 request_addr,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output res_t                                   res,
  output logic                                   f_we,
  output logic [$clog2(FREE_DEPTH)-1:0]          f_waddr,
  output logic [ADDR_W+SIZE_BITS-1:0]            f_wdata,
  output logic [$clog2(FREE_DEPTH)-1:0]          f_raddr,
  input  wire logic [ADDR_W+SIZE_BITS-1:0]       f_rdata,
  output logic                                   t_we,
  output logic [$clog2(TAKEN_DEPTH)-1:0]         t_waddr,
  output logic [ADDR_W+SIZE_BITS-1:0]            t_wdata,
  output logic [$clog2(TAKEN_DEPTH)-1:0]         t_raddr,
  input  wire logic [ADDR_W+SIZE_BITS-1:0]       t_rdata
);

  localparam int FA_W  = $clog2(FREE_DEPTH);
  localparam int TA_W  = $clog2(TAKEN_DEPTH);
  localparam int FC_W  = $clog2(FREE_DEPTH + 1);
  localparam int TC_W  = $clog2(TAKEN_DEPTH + 1);
  localparam int SUM_W = SIZE_BITS + FC_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FSCAN  = 9'b000000010,
    S_FPLACE = 9'b000000100,
    S_SHRD   = 9'b000001000,
    S_SHWR   = 9'b000010000,
    S_APPEND = 9'b000100000,
    S_TSCAN  = 9'b001000000,
    S_TPLACE = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // Latched request
  logic [SIZE_BITS-1:0] size;
  logic [ADDR_W-1:0]    addr;

  // Architectural state outside the RAMs
  logic [ADDR_W-1:0]      bp;
  logic [FC_W-1:0]        used;
  logic [SUM_W-1:0]       sum;
  logic [TAKEN_DEPTH-1:0] valid;

  // Scan bookkeeping
  logic [TA_W-1:0]      slot;
  logic [FC_W-1:0]      fidx;
  logic                 fdv;
  logic [FA_W-1:0]      fdidx;
  logic [TC_W-1:0]      tidx;
  logic                 tdv;
  logic [TA_W-1:0]      tdidx;
  logic                 have_pick;
  logic [FA_W-1:0]      pick_idx;
  logic [ADDR_W-1:0]    pick_start;
  logic [SIZE_BITS-1:0] pick_len;
  logic [FA_W-1:0]      j;
  logic                 hit;
  logic [TA_W-1:0]      hit_idx;
  logic [SIZE_BITS-1:0] hit_len;

  // Result registers
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   res_addr;
  logic                from_brk;

  // Combinational helpers
  logic                 slot_found;
  logic [TA_W-1:0]      slot_c;
  logic [SIZE_BITS-1:0] f_len;
  logic [ADDR_W-1:0]    f_start;
  logic [ADDR_W-1:0]    t_start;
  logic [SIZE_BITS-1:0] t_len;
  logic                 fits;
  logic                 take;
  logic [ADDR_W:0]      bp_sum;
  logic [SIZE_BITS-1:0] rest;
  logic [63:0]          sum_ext;

  assign f_len   = f_rdata[SIZE_BITS-1:0];
  assign f_start = f_rdata[ADDR_W+SIZE_BITS-1:SIZE_BITS];
  assign t_len   = t_rdata[SIZE_BITS-1:0];
  assign t_start = t_rdata[ADDR_W+SIZE_BITS-1:SIZE_BITS];
  assign fits    = f_len >= size;
  assign take    = fits && (!have_pick ||
                   (cfg.fit_mode == MODE_BEST  && f_len < pick_len) ||
                   (cfg.fit_mode == MODE_WORST && f_len > pick_len));
  assign bp_sum  = (ADDR_W+1)'(bp) + (ADDR_W+1)'(size);
  assign rest    = pick_len - size;
  assign sum_ext = 64'(sum);

  // Lowest free taken slot
  always_comb begin
    slot_found = 1'b0;
    slot_c     = '0;
    for (int i = TAKEN_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        slot_found = 1'b1;
        slot_c     = TA_W'(i);
      end
    end
  end

  // RAM ports
  always_comb begin
    f_raddr = (state == S_FSCAN) ? fidx[FA_W-1:0] : j + FA_W'(1);
    t_raddr = tidx[TA_W-1:0];
    f_we    = 1'b0;
    f_waddr = j;
    f_wdata = f_rdata;
    t_we    = 1'b0;
    t_waddr = slot;
    t_wdata = {pick_start, size};
    unique case (state)
      S_SHWR: begin
        f_we = 1'b1;
      end
      S_APPEND: begin
        t_we = 1'b1;
        if (rest != '0) begin
          f_we    = 1'b1;
          f_waddr = FA_W'(used - FC_W'(1));
          f_wdata = {pick_start + ADDR_W'(size), rest};
        end
      end
      S_FPLACE: begin
        t_wdata = {bp, size};
        t_we    = !have_pick && !bp_sum[ADDR_W];
      end
      S_TPLACE: begin
        f_waddr = used[FA_W-1:0];
        f_wdata = {addr, hit_len};
        f_we    = hit && (used < FC_W'(FREE_DEPTH));
      end
      default: ;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.result_addr  = res_addr;
    res.status       = status;
    res.from_break   = from_brk;
    res.free_bytes   = (|sum_ext[63:ADDR_W]) ? '1 : sum_ext[ADDR_W-1:0];
    res.free_entries = ENTRIES_W'(used);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      sum   <= '0;
      valid <= '0;
      bp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            size      <= SIZE_BITS'(request_size);
            addr      <= request_addr;
            status    <= ST_OK;
            res_addr  <= '0;
            from_brk  <= 1'b0;
            fidx      <= '0;
            fdv       <= 1'b0;
            tidx      <= '0;
            tdv       <= 1'b0;
            have_pick <= 1'b0;
            hit       <= 1'b0;
            slot      <= slot_c;
            if (req_type == REQ_FREE) begin
              state <= S_TSCAN;
            end else if (!slot_found) begin
              status <= ST_TAKEN_FULL;
              state  <= S_DONE;
            end else begin
              state <= S_FSCAN;
            end
          end
        end
        // one free entry per cycle, read data arriving in the cycle after its address
        S_FSCAN: begin
          fdv   <= fidx < used;
          fdidx <= fidx[FA_W-1:0];
          if (fidx < used) begin
            fidx <= fidx + FC_W'(1);
          end
          if (fdv && take) begin
            have_pick  <= 1'b1;
            pick_idx   <= fdidx;
            pick_start <= f_start;
            pick_len   <= f_len;
          end
          if (fidx == used && !fdv) begin
            state <= S_FPLACE;
          end
        end
        S_FPLACE: begin
          if (have_pick) begin
            j     <= pick_idx;
            state <= S_SHRD;
          end else if (bp_sum[ADDR_W]) begin
            status <= ST_EXHAUSTED;
            state  <= S_DONE;
          end else begin
            valid[slot] <= 1'b1;
            res_addr    <= bp;
            from_brk    <= 1'b1;
            bp          <= bp_sum[ADDR_W-1:0];
            state       <= S_DONE;
          end
        end
        // compaction: read entry j+1, then write it to j
        S_SHRD: begin
          if (FC_W'(j) + FC_W'(1) < used) begin
            state <= S_SHWR;
          end else begin
            state <= S_APPEND;
          end
        end
        S_SHWR: begin
          j     <= j + FA_W'(1);
          state <= S_SHRD;
        end
        S_APPEND: begin
          valid[slot] <= 1'b1;
          res_addr    <= pick_start;
          if (rest != '0) begin
            sum <= sum - SUM_W'(size);
          end else begin
            used <= used - FC_W'(1);
            sum  <= sum - SUM_W'(pick_len);
          end
          state <= S_DONE;
        end
        // taken table lookup, lowest matching valid slot wins
        S_TSCAN: begin
          tdv   <= tidx < TC_W'(TAKEN_DEPTH);
          tdidx <= tidx[TA_W-1:0];
          if (tidx < TC_W'(TAKEN_DEPTH)) begin
            tidx <= tidx + TC_W'(1);
          end
          if (tdv && !hit && valid[tdidx] && t_start == addr) begin
            hit     <= 1'b1;
            hit_idx <= tdidx;
            hit_len <= t_len;
          end
          if (tidx == TC_W'(TAKEN_DEPTH) && !tdv) begin
            state <= S_TPLACE;
          end
        end
        S_TPLACE: begin
          if (!hit) begin
            status <= ST_UNKNOWN;
          end else if (used >= FC_W'(FREE_DEPTH)) begin
            status <= ST_FREE_FULL;
          end else begin
            used           <= used + FC_W'(1);
            sum            <= sum + SUM_W'(hit_len);
            valid[hit_idx] <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // heap_base write reloads the break; write it only while idle, as this block does not enforce that
      if (cfg.bp_load) begin
        bp <= cfg.bp_value;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fit_strategy_heap_allocator_top.sv */
// Top level of the fit-strategy heap allocator: config, tables, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | req_type, request_size, request_addr
//  out      | out_valid / out_ready| result_addr, status, from_break,
//           |                      | free_bytes, free_entries
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An allocate scans the free table, then takes from the break, or takes from
// the free table and compacts it, shifting each later entry down with a read
// and then a write (one RAM port pair) before the new taken entry is written.
// A free scans every taken slot.
// One request is in flight at a time; a finished beat waits in the output
// register and the next request is accepted while it waits.
// Synchronous reset clears the tables' counts and valid bits; no clearing pass.
`default_nettype none

module fit_strategy_heap_allocator_top
  import fsba_pkg::*;
#(
  parameter int FREE_DEPTH  = FREE_DEPTH_DEF,
  parameter int TAKEN_DEPTH = TAKEN_DEPTH_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  req_type,
  input  wire logic [REQ_SIZE_W-1:0] request_size,
  input  wire logic [ADDR_W-1:0]     request_addr,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ADDR_W-1:0]          result_addr,
  output logic [STATUS_W-1:0]        status,
  output logic                       from_break,
  output logic [ADDR_W-1:0]          free_bytes,
  output logic [ENTRIES_W-1:0]       free_entries,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ADDR_W-1:0]     cfg_data
);

  localparam int FA_W  = $clog2(FREE_DEPTH);
  localparam int TA_W  = $clog2(TAKEN_DEPTH);
  localparam int ENT_W = ADDR_W + SIZE_BITS;

  logic [MODE_W-1:0] fit_mode;
  cfg_t              cfg;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  logic             f_we;
  logic [FA_W-1:0]  f_waddr;
  logic [ENT_W-1:0] f_wdata;
  logic [FA_W-1:0]  f_raddr;
  logic [ENT_W-1:0] f_rdata;
  logic             t_we;
  logic [TA_W-1:0]  t_waddr;
  logic [ENT_W-1:0] t_wdata;
  logic [TA_W-1:0]  t_raddr;
  logic [ENT_W-1:0] t_rdata;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= MODE_FIRST;
    end else if (cfg_valid && cfg_index == CFG_FIT_MODE) begin
      fit_mode <= cfg_data[MODE_W-1:0];
    end
  end

  assign cfg.fit_mode = fit_mode;
  assign cfg.bp_load  = cfg_valid && cfg_index == CFG_HEAP_BASE;
  assign cfg.bp_value = cfg_data;

  // Free table: {start, length}
  fsba_ram #(.WIDTH(ENT_W), .DEPTH(FREE_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // Taken table: {start, length}
  fsba_ram #(.WIDTH(ENT_W), .DEPTH(TAKEN_DEPTH)) u_taken_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  fsba_seq #(
    .FREE_DEPTH  (FREE_DEPTH),
    .TAKEN_DEPTH (TAKEN_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req_valid    (in_valid),
    .req_ready    (in_ready),
    .req_type     (req_type),
    .request_size (request_size),
    .request_addr (request_addr),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .f_we         (f_we),
    .f_waddr      (f_waddr),
    .f_wdata      (f_wdata),
    .f_raddr      (f_raddr),
    .f_rdata      (f_rdata),
    .t_we         (t_we),
    .t_waddr      (t_waddr),
    .t_wdata      (t_wdata),
    .t_raddr      (t_raddr),
    .t_rdata      (t_rdata)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result_addr  <= res.result_addr;
      status       <= res.status;
      from_break   <= res.from_break;
      free_bytes   <= res.free_bytes;
      free_entries <= res.free_entries;
    end
  end

endmodule

`default_nettype wire
